// File: src/spl_pkg.sv
`default_nettype none
package spl_pkg;

  // release coefficient format, Q0.16
  localparam int unsigned COEFF_W = 16;

  // configuration port
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // register indexes, decoded from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_COEFF     = 1'b1;

  localparam logic [31:0] THRESH_RESET = 32'd1038090;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd65522;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: src/spl_in_if.sv
`default_nettype none
interface spl_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_in;
  logic signed [SAMPLE_WIDTH-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

// File: src/spl_out_if.sv
`default_nettype none
interface spl_out_if #(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned GAIN_FRAC_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;
  logic [GAIN_FRAC_BITS:0]        applied_gain;

  modport source (output valid, output left_out, output right_out, output applied_gain,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input applied_gain,
                  output ready);
endinterface
`default_nettype wire

// File: src/stereo_peak_limiter.sv
`default_nettype none
// channel  dir  signals                                   note
// in_ch    in   valid ready left_in right_in              signed Q4.20 pair
// out_ch   out  valid ready left_out right_out            signed Q4.20, gain Q1.16
//               applied_gain
// apb      in   psel penable pwrite paddr pwdata          0x0 threshold, 0x4 coeff
//               prdata pready
//
// The attack path waits on the bit-serial gain divide; release needs no divide. One
// multiplier serves peak*gain, the release decay and both channel products in turn.
// in_ch.ready is high only while the sequencer is idle; a finished item waits in the
// output register, so the next pair is taken while out_ch is stalled.
// Synchronous reset restores unity gain and the register defaults.
module stereo_peak_limiter #(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  spl_in_if.sink                             in_ch,
  spl_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spl_pkg::APB_AW-1:0]    paddr,
  input  wire logic [spl_pkg::APB_DW-1:0]    pwdata,
  output logic      [spl_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned TW = SAMPLE_WIDTH - 1;
  localparam int unsigned GW = GAIN_FRAC_BITS + 1;
  localparam int unsigned PW = SW + GW;
  localparam int unsigned CF = spl_pkg::COEFF_W;
  localparam logic [GW-1:0] UNITY = GW'(1) << GAIN_FRAC_BITS;
  localparam logic [PW-1:0] RND   = PW'((GW'(1) << GAIN_FRAC_BITS) - GW'(1));

  typedef enum logic [3:0] {
    S_IDLE, S_PEAK, S_MPG, S_CMP, S_DIV, S_REL, S_ML, S_MR, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [TW-1:0] thr;
  logic [CF-1:0] coeff;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      spl_pkg::REG_THRESHOLD: prdata = spl_pkg::APB_DW'(thr);
      spl_pkg::REG_COEFF:     prdata = spl_pkg::APB_DW'(coeff);
      default:                prdata = '0;
    endcase
  end

  // item state
  logic [SW-1:0] lmag, rmag, peak;
  logic          lneg, rneg;
  logic [GW-1:0] gain;
  logic [GW-1:0] gap;
  logic [SW-1:0] left_res;

  // output register
  logic                 out_valid;
  logic signed [SW-1:0] left_q, right_q;
  logic [GW-1:0]        gain_q;

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.left_out     = left_q;
  assign out_ch.right_out    = right_q;
  assign out_ch.applied_gain = gain_q;

  // shared multiplier
  logic          mul_en;
  logic [SW-1:0] mul_a;
  logic [GW-1:0] mul_b;
  logic [PW-1:0] prod;

  spl_mul #(.AW(SW), .BW(GW)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign gap = UNITY - gain;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = peak;
    mul_b  = gain;
    unique case (state)
      S_MPG: begin
        mul_en = 1'b1;
      end
      S_CMP: begin
        mul_en = 1'b1;
        mul_a  = SW'(coeff);
        mul_b  = gap;
      end
      S_ML: begin
        mul_en = 1'b1;
        mul_a  = lmag;
      end
      S_MR: begin
        mul_en = 1'b1;
        mul_a  = rmag;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // divider
  logic               div_start;
  logic [GW-1:0]      quot;
  spl_pkg::div_stat_t div_stat;
  logic               over;

  assign over      = prod > PW'({thr, {GAIN_FRAC_BITS{1'b0}}});
  assign div_start = (state == S_CMP) && over;

  spl_div #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .thr   (thr),
    .peak  (peak),
    .quot  (quot),
    .stat  (div_stat)
  );

  // floor(sample * gain / unity) from the product magnitude and sign
  logic          sc_neg;
  logic [PW-1:0] prod_rnd;
  logic [SW:0]   sc_mag;
  logic [SW:0]   sc_val;
  logic [SW-1:0] scaled;

  assign sc_neg   = (state == S_FIN) ? rneg : lneg;
  assign prod_rnd = prod + RND;
  assign sc_mag   = sc_neg ? prod_rnd[PW-1:GAIN_FRAC_BITS] : prod[PW-1:GAIN_FRAC_BITS];
  assign sc_val   = sc_neg ? (~sc_mag + 1'b1) : sc_mag;
  assign scaled   = sc_val[SW-1:0];

  // input magnitudes; the most negative sample maps to 2^(SW-1)
  logic [SW-1:0] l_abs, r_abs;
  assign l_abs = in_ch.left_in[SW-1]  ? (~in_ch.left_in + 1'b1)  : in_ch.left_in;
  assign r_abs = in_ch.right_in[SW-1] ? (~in_ch.right_in + 1'b1) : in_ch.right_in;

  logic [PW-1:0] rel_term;
  assign rel_term = prod >> CF;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      gain      <= UNITY;
      thr       <= spl_pkg::THRESH_RESET[TW-1:0];
      coeff     <= spl_pkg::COEFF_RESET;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          spl_pkg::REG_THRESHOLD: thr   <= pwdata[TW-1:0];
          spl_pkg::REG_COEFF:     coeff <= pwdata[CF-1:0];
          default:                thr   <= thr;
        endcase
      end
      // the final state reloads the output register itself
      if (out_valid && out_ch.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            lmag  <= l_abs;
            rmag  <= r_abs;
            lneg  <= in_ch.left_in[SW-1];
            rneg  <= in_ch.right_in[SW-1];
            state <= S_PEAK;
          end
        end
        S_PEAK: begin
          peak  <= (lmag > rmag) ? lmag : rmag;
          state <= S_MPG;
        end
        S_MPG: begin
          state <= S_CMP;
        end
        S_CMP: begin
          state <= over ? S_DIV : S_REL;
        end
        S_DIV: begin
          if (div_stat.done) begin
            gain  <= quot;
            state <= S_ML;
          end
        end
        S_REL: begin
          gain  <= UNITY - rel_term[GW-1:0];
          state <= S_ML;
        end
        S_ML: begin
          state <= S_MR;
        end
        S_MR: begin
          left_res <= scaled;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ch.ready) begin
            left_q    <= left_res;
            right_q   <= scaled;
            gain_q    <= gain;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/spl_mul.sv
`default_nettype none
module spl_mul #(
  parameter int unsigned AW = 24,
  parameter int unsigned BW = 17
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic      [AW+BW-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (AW+BW)'(a) * (AW+BW)'(b);
    end
  end

endmodule
`default_nettype wire

// File: src/spl_div.sv
`default_nettype none
// Restoring divide of (thr << GAIN_FRAC_BITS) / peak, one quotient bit a cycle.
// Only the low GAIN_FRAC_BITS+1 quotient bits are formed: the caller starts it
// only when the quotient is known to be below unity.
module spl_div #(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [SAMPLE_WIDTH-2:0]   thr,
  input  wire logic [SAMPLE_WIDTH-1:0]   peak,
  output logic      [GAIN_FRAC_BITS:0]   quot,
  output spl_pkg::div_stat_t             stat
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned GW = GAIN_FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(GW + 1);

  logic [SW-2:0] rem;
  logic [GW-1:0] qr;    // dividend bits shift out on top, quotient bits in below
  logic [CW-1:0] cnt;
  logic [SW-1:0] trial;
  logic [SW-1:0] diff;
  logic          ge;

  assign trial = {rem, qr[GW-1]};
  assign ge    = trial >= peak;
  assign diff  = trial - peak;
  assign quot  = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !start && stat.busy && (cnt == CW'(1));
      if (start) begin
        rem       <= {1'b0, thr[SW-2:1]};
        qr        <= {thr[0], {(GW-1){1'b0}}};
        cnt       <= CW'(GW);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem <= ge ? diff[SW-2:0] : trial[SW-2:0];
        qr  <= {qr[GW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/spl_checker.sv
`default_nettype none
module spl_checker #(
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [GAIN_FRAC_BITS:0] applied_gain
);

  localparam logic [GAIN_FRAC_BITS:0] UNITY = (GAIN_FRAC_BITS+1)'(1) << GAIN_FRAC_BITS;

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // one pair at a time: taking an item closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // gain never rises above unity
  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> applied_gain <= UNITY)
    else $error("gain above unity");

  // reset leaves the block empty and open for input
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not clear the block");

endmodule

bind stereo_peak_limiter spl_checker #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_spl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .applied_gain (out_ch.applied_gain)
);
`default_nettype wire

// File: test/stereo_peak_limiter_checker.sv
`default_nettype none
module stereo_peak_limiter_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  spl_in_if                               in_mon,
  spl_out_if                              out_mon,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic                       pready,
  input  wire logic [spl_pkg::APB_AW-1:0] paddr,
  input  wire logic [spl_pkg::APB_DW-1:0] pwdata,
  output int                              fail_count,
  output int                              pending
);
  import spl_pkg::*;

  localparam logic [16:0] UNITY = 17'h10000;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [16:0]        gain;
  } limited_pair_t;

  logic [22:0]        threshold;
  logic [COEFF_W-1:0] coeff;
  logic [16:0]        gain_now;
  limited_pair_t      limited_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Updates the shared gain and returns the scaled pair.
  function automatic limited_pair_t limit_pair(input logic signed [23:0] l,
                                               input logic signed [23:0] r);
    logic [23:0]        mag_l, mag_r, peak;
    logic [40:0]        peak_x_gain;
    logic [38:0]        limit_level;
    logic [16:0]        gap;
    logic [32:0]        decay;
    logic signed [41:0] prod_l, prod_r;
    limited_pair_t      res;
    // -2^23 negates to the same bit pattern, read as unsigned 2^23
    mag_l = l[23] ? -l : l;
    mag_r = r[23] ? -r : r;
    peak = (mag_l > mag_r) ? mag_l : mag_r;
    peak_x_gain = 41'(peak) * 41'(gain_now);
    limit_level = {threshold, 16'b0};
    if (peak_x_gain > 41'(limit_level)) begin
      gain_now = 17'(limit_level / 39'(peak));
    end else begin
      gap = UNITY - gain_now;
      decay = 33'(gap) * 33'(coeff);
      gain_now = UNITY - 17'(decay[32:16]);
    end
    prod_l = l * $signed({1'b0, gain_now});
    prod_r = r * $signed({1'b0, gain_now});
    // arithmetic shift: floor toward minus infinity
    res.left = prod_l[39:16];
    res.right = prod_r[39:16];
    res.gain = gain_now;
    return res;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    limited_pair_t want;
    if (rst) begin
      threshold = THRESH_RESET[22:0];
      coeff = COEFF_RESET;
      gain_now = UNITY;
      limited_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_THRESHOLD) begin
          threshold = pwdata[22:0];
        end else begin
          coeff = pwdata[COEFF_W-1:0];
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (limited_q.size() == 0) begin
          $error("result item with no pending input");
          fail_count++;
        end else begin
          want = limited_q.pop_front();
          compare_field("left_out", $signed(want.left), $signed(out_mon.left_out));
          compare_field("right_out", $signed(want.right), $signed(out_mon.right_out));
          compare_field("applied_gain", want.gain, out_mon.applied_gain);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        limited_q.push_back(limit_pair(in_mon.left_in, in_mon.right_in));
      end
    end
    pending = limited_q.size();
  end
endmodule
`default_nettype wire

// File: test/stereo_peak_limiter_test.sv
`default_nettype none
module stereo_peak_limiter_test;
  import spl_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic [23:0] MAX_POS = 24'h7fffff;
  localparam logic [23:0] MAX_NEG = 24'h800000;

  logic                clk;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  wire  [APB_DW-1:0]   prdata;
  wire                 pready;
  int                  fail_count, pending;
  int                  burst_left;
  int                  run_left;
  logic                ready_run;
  bit                  no_idle;
  int                  quiet_cycles;

  spl_in_if  #(.SAMPLE_WIDTH(24)) in_ch ();
  spl_out_if #(.SAMPLE_WIDTH(24), .GAIN_FRAC_BITS(16)) out_ch ();

  stereo_peak_limiter dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stereo_peak_limiter_checker checker_inst (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: runs of ready and stall of random length
  always @(negedge clk) begin
    if (run_left == 0) begin
      run_left = $urandom_range(1, 8);
      ready_run = no_idle || ($urandom_range(0, 2) != 0);
    end
    run_left--;
    out_ch.ready <= ready_run;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_pair(input logic [23:0] l, input logic [23:0] r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!no_idle && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.left_in <= l;
    in_ch.right_in <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper bits are junk; the block keeps only the register width
  task automatic set_limits(input logic [22:0] thr, input logic [15:0] rel);
    write_reg(REG_THRESHOLD, {9'($urandom()), thr});
    write_reg(REG_COEFF, {16'($urandom()), rel});
  endtask

  function automatic logic [23:0] pick_sample(input int kind);
    logic [23:0] m;
    case (kind)
      0: return 24'($urandom());
      1: begin
        m = 24'($urandom_range(6000000, 8388607));
        return $urandom_range(0, 1) ? -m : m;
      end
      2: return 24'($urandom_range(0, 4095)) - 24'd2048;
      3: return 24'd0;
      4: begin
        case ($urandom_range(0, 3))
          0: return MAX_POS;
          1: return MAX_NEG;
          2: return 24'd1;
          default: return 24'hffffff;
        endcase
      end
      default: return 24'($urandom_range(0, 2097151)) - 24'd1048576;
    endcase
  endfunction

  task automatic random_phase(input int count);
    int kind, seg;
    seg = 0;
    kind = 0;
    for (int i = 0; i < count; i++) begin
      // segments of one kind: loud stretches and silent stretches drive
      // long attack/release runs
      if (seg == 0) begin
        seg = $urandom_range(1, 20);
        kind = $urandom_range(0, 5);
      end
      seg--;
      send_pair(pick_sample(kind), pick_sample($urandom_range(0, 1) ? kind : 0));
    end
  endtask

  function automatic logic [22:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return 23'd0;
      1: return 23'h7fffff;
      2: return 23'($urandom());
      default: return 23'($urandom_range(200000, 1100000));
    endcase
  endfunction

  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom());
      default: return 16'($urandom_range(60000, 65535));
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    out_ch.ready = 1'b0;
    burst_left = 0;
    run_left = 0;
    ready_run = 1'b0;
    no_idle = 1'b0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default limits: full scale both signs, most negative sample, then release
    send_pair(24'd0, 24'd0);
    send_pair(MAX_POS, MAX_POS);
    send_pair(MAX_NEG, MAX_NEG);
    send_pair(MAX_NEG, MAX_POS);
    send_pair(MAX_POS, MAX_NEG);
    send_pair(24'd1, 24'hffffff);
    repeat (3) send_pair(24'd0, 24'd0);
    // zero threshold clamps any signal; zero coefficient snaps back to unity
    set_limits(23'd0, 16'd0);
    send_pair(24'd5, 24'd0);
    send_pair(24'd0, 24'd0);
    send_pair(MAX_NEG, 24'd3);
    send_pair(24'd0, 24'hfffffd);
    send_pair(24'd0, 24'd0);
    // top threshold, slowest release
    set_limits(23'h7fffff, 16'hffff);
    send_pair(MAX_NEG, 24'd0);
    send_pair(MAX_POS, MAX_NEG);
    repeat (3) send_pair(24'd0, 24'd0);
    // small gap to unity truncates away under the default coefficient
    set_limits(23'd1038090, 16'd65522);
    send_pair(24'h100010, 24'd0);
    repeat (4) send_pair(24'd0, 24'd0);

    for (int p = 0; p < 6; p++) begin
      set_limits(pick_threshold(), pick_coeff());
      no_idle = (p == 2);
      random_phase(100);
    end
    no_idle = 1'b0;

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
src/spl_pkg.sv
src/spl_in_if.sv
src/spl_out_if.sv
src/spl_mul.sv
src/spl_div.sv
src/stereo_peak_limiter.sv
src/spl_checker.sv
test/stereo_peak_limiter_checker.sv
test/stereo_peak_limiter_test.sv
